// ===== hw/rtl/irpf_pkg.sv =====
package irpf_pkg;

    // Frame header constants.
    localparam logic [7:0] HDR_OPCODE  = 8'h54;
    localparam logic [7:0] HDR_VERSION = 8'h01;
    localparam int         HDR_BYTES   = 10;

    // Reflected CRC-8 polynomial.
    localparam logic [7:0] CRC_POLY = 8'h8C;

    // Shortest code that still makes a frame.
    localparam int MIN_DURATIONS = 5;

    // Result status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FEW  = 2'd1;
    localparam logic [1:0] ST_MANY = 2'd2;
    localparam logic [1:0] ST_OVF  = 2'd3;

    // Configuration register indexes.
    localparam logic REG_CARRIER = 1'b0;

    // One queued duration item.
    typedef struct packed {
        logic [15:0] duration;
        logic        last;
    } t_item;

    // Commands from the sequencer to the dictionary unit.
    typedef struct packed {
        logic cmp;
        logic pick;
        logic clear;
    } t_dict_req;

    // Answer of the dictionary unit during a pick.
    typedef struct packed {
        logic [3:0] nib;
        logic       ovf;
    } t_dict_rsp;

    // Two times match when they differ by at most one.
    function automatic logic near_eq(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] ae;
        logic [16:0] be;
        ae = {1'b0, a};
        be = {1'b0, b};
        return (ae == be) || (ae == be + 17'd1) || (be == ae + 17'd1);
    endfunction

    // One byte of the reflected CRC-8.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/irpf_if.sv =====
// Input channel: one duration item per handshake.
interface irpf_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] duration;
    logic        last;

    modport source (output valid, output duration, output last, input ready);
    modport sink (input valid, input duration, input last, output ready);
endinterface

// Output channel: one frame word item per handshake.
interface irpf_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] frame_word;
    logic [3:0]  bytes_valid;
    logic [1:0]  status;
    logic        end_of_frame;

    modport source (output valid, output frame_word, output bytes_valid,
                    output status, output end_of_frame, input ready);
    modport sink (input valid, input frame_word, input bytes_valid,
                  input status, input end_of_frame, output ready);
endinterface

// ===== hw/rtl/ir_pulse_dictionary_framer_core.sv =====
// Channel   | Direction | Payload                                          | Handshake
// i_in      | in        | duration[15:0], last                             | valid/ready
// o_out     | out       | frame_word[63:0], bytes_valid[3:0], status[1:0], | valid/ready
//           |           | end_of_frame                                     |
// APB       | in/out    | carrier_code at byte address 0                   | psel/penable
//
// A duration that opens a pair is taken in the idle state; one that closes a pair
// goes on through the dictionary compare, then the pick or append. The frame is built in a
// CRC pass over the payload and then an output pass over every frame byte; each byte takes
// a fetch state and a take state around the registered read of the index byte memory.
// Reset is synchronous and active low; it empties the input queue and the dictionary.
// The input queue holds two items; an output register holds one result word.
module ir_pulse_dictionary_framer_core #(
    parameter int MAX_PAIRS     = 16,
    parameter int MAX_DURATIONS = 1024,
    parameter int DICT_BYTES    = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    irpf_in_if.sink     i_in,
    irpf_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]      r_carrier;
    logic            q_valid;
    logic            q_ready;
    irpf_pkg::t_item q_item;

    assign pready = 1'b1;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carrier <= 8'd0;
        end else if (psel && penable && pwrite && paddr[2] == irpf_pkg::REG_CARRIER) begin
            r_carrier <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == irpf_pkg::REG_CARRIER) ? {24'd0, r_carrier} : 32'd0;

    irpf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_ready (q_ready)
    );

    irpf_back #(
        .MAX_PAIRS     (MAX_PAIRS),
        .MAX_DURATIONS (MAX_DURATIONS),
        .DICT_BYTES    (DICT_BYTES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_ready (q_ready),
        .i_carrier (r_carrier),
        .o_out     (o_out)
    );

endmodule

// ===== hw/rtl/irpf_front.sv =====
// Front end: takes duration items into a two-entry queue.
module irpf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    irpf_in_if.sink           i_in,
    output logic              o_q_valid,
    output irpf_pkg::t_item   o_q_item,
    input  logic              i_q_ready
);

    irpf_pkg::t_item r_q [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    logic            push;
    logic            pop;

    assign i_in.ready = (r_cnt != 2'd2);
    assign push       = i_in.valid && i_in.ready;
    assign pop        = o_q_valid && i_q_ready;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_item   = r_q[r_rp];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{duration: i_in.duration, last: i_in.last};
        end
    end

    // Queue pointers and fill.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== hw/rtl/irpf_dict.sv =====
// Dictionary unit: parallel near-match compare, then a priority pick or append.
module irpf_dict #(
    parameter int  MAX_PAIRS = 16,
    localparam int FILL_W    = $clog2(MAX_PAIRS + 1),
    localparam int DIDX_W    = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  irpf_pkg::t_dict_req   i_req,
    input  logic [15:0]           i_hi,
    input  logic [15:0]           i_lo,
    output irpf_pkg::t_dict_rsp   o_rsp,
    output logic [FILL_W-1:0]     o_fill,
    input  logic [DIDX_W-1:0]     i_rd_idx,
    output logic [31:0]           o_rd_data
);

    logic [31:0]          r_dict [MAX_PAIRS];
    logic [MAX_PAIRS-1:0] r_match;
    logic [FILL_W-1:0]    r_fill;
    logic                 hit;
    logic [3:0]           first;
    logic                 full;

    assign o_fill    = r_fill;
    assign o_rd_data = r_dict[i_rd_idx];
    assign full      = (r_fill == FILL_W'(MAX_PAIRS));
    assign hit       = |r_match;

    // Lowest matching entry wins.
    always_comb begin
        first = 4'd0;
        for (int k = MAX_PAIRS - 1; k >= 0; k--) begin
            if (r_match[k]) begin
                first = 4'(k);
            end
        end
    end

    always_comb begin
        o_rsp.nib = hit ? first : (full ? 4'd0 : 4'(r_fill));
        o_rsp.ovf = i_req.pick && !hit && full;
    end

    // Compare every stored entry against the new pair.
    always_ff @(posedge i_clk) begin
        if (i_req.cmp) begin
            for (int k = 0; k < MAX_PAIRS; k++) begin
                r_match[k] <= (FILL_W'(k) < r_fill) &&
                              irpf_pkg::near_eq(r_dict[k][31:16], i_hi) &&
                              irpf_pkg::near_eq(r_dict[k][15:0], i_lo);
            end
        end
    end

    // Append a new pair when nothing matched and the dictionary is not full.
    always_ff @(posedge i_clk) begin
        if (i_req.pick && !hit && !full) begin
            r_dict[r_fill[DIDX_W-1:0]] <= {i_hi, i_lo};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_req.clear) begin
            r_fill <= '0;
        end else if (i_req.pick && !hit && !full) begin
            r_fill <= r_fill + FILL_W'(1);
        end
    end

endmodule

// ===== hw/rtl/irpf_back.sv =====
// Back end: pairs durations, keeps index nibbles, and builds the frame.
module irpf_back #(
    parameter int MAX_PAIRS     = 16,
    parameter int MAX_DURATIONS = 1024,
    parameter int DICT_BYTES    = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  irpf_pkg::t_item i_q_item,
    output logic            o_q_ready,
    input  logic [7:0]      i_carrier,
    irpf_out_if.source      o_out
);

    localparam int CNT_W      = $clog2(MAX_DURATIONS + 2);
    localparam int PAIR_SLOTS = (MAX_DURATIONS + 1) / 2;
    localparam int PIDX_W     = $clog2(PAIR_SLOTS);
    localparam int PAIRS_W    = $clog2(PAIR_SLOTS + 1);
    localparam int BYTE_SLOTS = (PAIR_SLOTS + 1) / 2;
    localparam int BADDR_W    = $clog2(BYTE_SLOTS);
    localparam int FRAME_MAX  = irpf_pkg::HDR_BYTES + DICT_BYTES + BYTE_SLOTS;
    localparam int POS_W      = $clog2(FRAME_MAX + 1);
    localparam int FILL_W     = $clog2(MAX_PAIRS + 1);
    localparam int DIDX_W     = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int PAY_START  = irpf_pkg::HDR_BYTES;
    localparam int NIB_START  = irpf_pkg::HDR_BYTES + DICT_BYTES;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CMP   = 4'd1;
    localparam logic [3:0] S_PICK  = 4'd2;
    localparam logic [3:0] S_FIN   = 4'd3;
    localparam logic [3:0] S_ERR   = 4'd4;
    localparam logic [3:0] S_FETCH = 4'd5;
    localparam logic [3:0] S_TAKE  = 4'd6;
    localparam logic [3:0] S_CLR   = 4'd7;

    logic [3:0]         r_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [15:0]        r_pend;
    logic               r_many;
    logic               r_ovf;
    logic               r_last;
    logic               r_padded;
    logic [PIDX_W-1:0]  r_pidx;
    logic [3:0]         r_hold;
    logic [15:0]        r_op_hi;
    logic [15:0]        r_op_lo;
    logic [1:0]         r_status;
    logic [7:0]         r_crc;
    logic [POS_W-1:0]   r_pos;
    logic [POS_W-1:0]   r_len;
    logic [PAIRS_W-1:0] r_pairs;
    logic               r_emit;
    logic [7:0]         r_hb;
    logic               r_is_mem;
    logic [63:0]        r_word;
    logic [2:0]         r_wpos;
    logic [7:0]         r_mem [BYTE_SLOTS];
    logic [7:0]         r_rd;

    logic               r_ov;
    logic [63:0]        r_ow;
    logic [3:0]         r_onb;
    logic [1:0]         r_ost;
    logic               r_oeof;

    irpf_pkg::t_dict_req dreq;
    irpf_pkg::t_dict_rsp drsp;
    logic [FILL_W-1:0]   dfill;
    logic [DIDX_W-1:0]   drd_idx;
    logic [31:0]         drd_data;

    logic               out_free;
    logic               out_load;
    logic [CNT_W-1:0]   cnt_inc;
    logic [CNT_W:0]     cnt_p1;
    logic [PAIRS_W-1:0] fin_pairs;
    logic [PAIRS_W-1:0] fin_dbytes;
    logic [1:0]         fin_status;
    logic               mem_we;
    logic [BADDR_W-1:0] mem_waddr;
    logic [7:0]         mem_wdata;
    logic [BADDR_W-1:0] mem_raddr;
    logic [POS_W-1:0]   dict_k;
    logic [POS_W-1:0]   dict_e;
    logic [7:0]         fetch_byte;
    logic               fetch_mem;
    logic [7:0]         take_byte;
    logic [63:0]        word_next;
    logic               at_end;
    logic [15:0]        len16;
    logic [15:0]        pairs16;

    irpf_dict #(.MAX_PAIRS(MAX_PAIRS)) u_dict (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (dreq),
        .i_hi      (r_op_hi),
        .i_lo      (r_op_lo),
        .o_rsp     (drsp),
        .o_fill    (dfill),
        .i_rd_idx  (drd_idx),
        .o_rd_data (drd_data)
    );

    assign o_q_ready         = (r_state == S_IDLE);
    assign out_free          = !r_ov || o_out.ready;
    assign o_out.valid       = r_ov;
    assign o_out.frame_word  = r_ow;
    assign o_out.bytes_valid = r_onb;
    assign o_out.status      = r_ost;
    assign o_out.end_of_frame = r_oeof;

    assign dreq.cmp   = (r_state == S_CMP);
    assign dreq.pick  = (r_state == S_PICK);
    assign dreq.clear = (r_state == S_CLR);

    assign cnt_inc    = r_cnt + CNT_W'(1);
    assign cnt_p1     = {1'b0, r_cnt} + (CNT_W + 1)'(1);
    assign fin_pairs  = PAIRS_W'(cnt_p1 >> 1);
    assign fin_dbytes = PAIRS_W'(({1'b0, fin_pairs} + (PAIRS_W + 1)'(1)) >> 1);

    // A result item is loaded into the output register in these cycles.
    assign out_load = out_free &&
                      ((r_state == S_ERR) ||
                       (r_state == S_TAKE && r_emit && (r_wpos == 3'd7 || at_end)));

    // Status with too many first, then too few, then overflow.
    always_comb begin
        if (r_many) begin
            fin_status = irpf_pkg::ST_MANY;
        end else if (r_cnt < CNT_W'(irpf_pkg::MIN_DURATIONS)) begin
            fin_status = irpf_pkg::ST_FEW;
        end else if (r_ovf) begin
            fin_status = irpf_pkg::ST_OVF;
        end else begin
            fin_status = irpf_pkg::ST_OK;
        end
    end

    // Index bytes are written once both nibbles are known, or padded at the end.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = BADDR_W'(r_pidx >> 1);
        mem_wdata = {r_hold, drsp.nib};
        if (r_state == S_PICK && r_pidx[0]) begin
            mem_we = 1'b1;
        end else if (r_state == S_FIN && !(!r_many && r_cnt[0] && !r_padded) &&
                     fin_status == irpf_pkg::ST_OK && fin_pairs[0]) begin
            mem_we    = 1'b1;
            mem_waddr = BADDR_W'((fin_pairs - PAIRS_W'(1)) >> 1);
            mem_wdata = {r_hold, 4'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_mem[mem_raddr];
    end

    // Byte source for the current frame position.
    assign len16     = 16'(r_len);
    assign pairs16   = 16'(r_pairs);
    assign dict_k    = r_pos - POS_W'(PAY_START);
    assign dict_e    = dict_k >> 2;
    assign drd_idx   = DIDX_W'(dict_e);
    assign mem_raddr = BADDR_W'(r_pos - POS_W'(NIB_START));

    always_comb begin
        fetch_byte = 8'd0;
        fetch_mem  = 1'b0;
        if (r_pos < POS_W'(PAY_START)) begin
            case (r_pos)
                POS_W'(0): fetch_byte = irpf_pkg::HDR_OPCODE;
                POS_W'(1): fetch_byte = len16[15:8];
                POS_W'(2): fetch_byte = len16[7:0];
                POS_W'(3): fetch_byte = i_carrier;
                POS_W'(4): fetch_byte = pairs16[15:8];
                POS_W'(5): fetch_byte = pairs16[7:0];
                POS_W'(8): fetch_byte = irpf_pkg::HDR_VERSION;
                POS_W'(9): fetch_byte = r_crc;
                default:   fetch_byte = 8'd0;
            endcase
        end else if (r_pos < POS_W'(NIB_START)) begin
            if (dict_e < POS_W'(dfill)) begin
                case (dict_k[1:0])
                    2'd0:    fetch_byte = drd_data[31:24];
                    2'd1:    fetch_byte = drd_data[23:16];
                    2'd2:    fetch_byte = drd_data[15:8];
                    default: fetch_byte = drd_data[7:0];
                endcase
            end
        end else begin
            fetch_mem = 1'b1;
        end
    end

    assign take_byte = r_is_mem ? r_rd : r_hb;
    assign at_end    = (r_pos == r_len - POS_W'(1));

    always_comb begin
        word_next = r_word;
        word_next[{~r_wpos, 3'b000} +: 8] = take_byte;
    end

    // Output valid: set on a load, cleared once the item is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_pend   <= 16'd0;
            r_many   <= 1'b0;
            r_ovf    <= 1'b0;
            r_padded <= 1'b0;
            r_last   <= 1'b0;
            r_emit   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        if (r_cnt < CNT_W'(MAX_DURATIONS)) begin
                            r_cnt <= cnt_inc;
                            if (cnt_inc[0]) begin
                                r_pend <= i_q_item.duration;
                                if (i_q_item.last) begin
                                    r_state <= S_FIN;
                                end
                            end else begin
                                r_op_hi <= r_pend;
                                r_op_lo <= i_q_item.duration;
                                r_pidx  <= PIDX_W'((cnt_inc - CNT_W'(1)) >> 1);
                                r_last  <= i_q_item.last;
                                r_state <= S_CMP;
                            end
                        end else begin
                            r_cnt  <= CNT_W'(MAX_DURATIONS + 1);
                            r_many <= 1'b1;
                            if (i_q_item.last) begin
                                r_state <= S_FIN;
                            end
                        end
                    end
                end
                S_CMP: begin
                    r_state <= S_PICK;
                end
                S_PICK: begin
                    if (!r_pidx[0]) begin
                        r_hold <= drsp.nib;
                    end
                    if (drsp.ovf) begin
                        r_ovf <= 1'b1;
                    end
                    r_state <= r_last ? S_FIN : S_IDLE;
                end
                S_FIN: begin
                    if (!r_many && r_cnt[0] && !r_padded) begin
                        // Odd count: the final high time pairs with a zero low time.
                        r_op_hi  <= r_pend;
                        r_op_lo  <= 16'd0;
                        r_pidx   <= PIDX_W'((r_cnt - CNT_W'(1)) >> 1);
                        r_padded <= 1'b1;
                        r_last   <= 1'b1;
                        r_state  <= S_CMP;
                    end else if (fin_status != irpf_pkg::ST_OK) begin
                        r_status <= fin_status;
                        r_state  <= S_ERR;
                    end else begin
                        r_pairs <= fin_pairs;
                        r_len   <= POS_W'(NIB_START) + POS_W'(fin_dbytes);
                        r_pos   <= POS_W'(PAY_START);
                        r_crc   <= 8'd0;
                        r_emit  <= 1'b0;
                        r_state <= S_FETCH;
                    end
                end
                S_ERR: begin
                    if (out_free) begin
                        r_ow    <= 64'd0;
                        r_onb   <= 4'd0;
                        r_ost   <= r_status;
                        r_oeof  <= 1'b1;
                        r_state <= S_CLR;
                    end
                end
                S_FETCH: begin
                    r_hb     <= fetch_byte;
                    r_is_mem <= fetch_mem;
                    r_state  <= S_TAKE;
                end
                S_TAKE: begin
                    if (!r_emit) begin
                        // First pass: CRC over the payload.
                        r_crc <= irpf_pkg::crc8_byte(r_crc, take_byte);
                        if (at_end) begin
                            r_emit <= 1'b1;
                            r_pos  <= '0;
                            r_wpos <= 3'd0;
                            r_word <= 64'd0;
                        end else begin
                            r_pos <= r_pos + POS_W'(1);
                        end
                        r_state <= S_FETCH;
                    end else if (r_wpos == 3'd7 || at_end) begin
                        if (out_free) begin
                            r_ow   <= word_next;
                            r_onb  <= {1'b0, r_wpos} + 4'd1;
                            r_ost  <= irpf_pkg::ST_OK;
                            r_oeof <= at_end;
                            r_word <= 64'd0;
                            r_wpos <= 3'd0;
                            if (at_end) begin
                                r_state <= S_CLR;
                            end else begin
                                r_pos   <= r_pos + POS_W'(1);
                                r_state <= S_FETCH;
                            end
                        end
                    end else begin
                        r_word  <= word_next;
                        r_wpos  <= r_wpos + 3'd1;
                        r_pos   <= r_pos + POS_W'(1);
                        r_state <= S_FETCH;
                    end
                end
                S_CLR: begin
                    r_cnt    <= '0;
                    r_pend   <= 16'd0;
                    r_many   <= 1'b0;
                    r_ovf    <= 1'b0;
                    r_padded <= 1'b0;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== dv/ir_pulse_dictionary_framer_core_tb.sv =====
module ir_pulse_dictionary_framer_core_tb;

    localparam int NUM_PAIRS   = 16;
    localparam int NUM_DUR     = 1024;
    localparam int DICT_LEN    = 64;
    localparam int SLOTS       = (NUM_DUR + 1) / 2;
    localparam int FRAME_LEN   = irpf_pkg::HDR_BYTES + DICT_LEN + (SLOTS + 1) / 2;
    localparam int CYCLE_LIMIT = 3000000;
    localparam logic [2:0] ADDR_CARRIER = {irpf_pkg::REG_CARRIER, 2'b00};

    typedef struct packed {
        logic [63:0] frame_word;
        logic [3:0]  bytes_valid;
        logic [1:0]  status;
        logic        end_of_frame;
    } t_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    irpf_in_if  in_ch ();
    irpf_out_if out_ch ();

    ir_pulse_dictionary_framer_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Framer state as the testbench tracks it.
    logic [31:0] dict_pairs [NUM_PAIRS];
    int          dict_fill;
    logic [3:0]  pair_nibbles [SLOTS];
    int          dur_count;
    logic [15:0] open_high;
    bit          flag_many;
    bit          flag_ovf;
    logic [7:0]  carrier;

    t_word             words_due [$];
    irpf_pkg::t_item   durations_todo [$];

    int  n_cycles;
    int  n_mismatch;
    int  n_words;
    int  n_frames;
    int  n_errors;
    int  n_queued;
    bit  slot_full;
    int  burst_left;
    int  gap_left;
    int  ready_pct;

    // Clock and reset.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic bit close_enough(logic [15:0] a, logic [15:0] b);
        int d;
        d = int'(a) - int'(b);
        return d >= -1 && d <= 1;
    endfunction

    function automatic logic [7:0] crc_step(logic [7:0] crc, logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[0]) c = (c >> 1) ^ 8'h8C;
            else c = c >> 1;
        end
        return c;
    endfunction

    // Match a pair against the dictionary, or append it.
    function automatic void file_pair(logic [15:0] hi, logic [15:0] lo, int slot);
        logic [3:0] nib;
        bit         hit;
        nib = 4'd0;
        hit = 1'b0;
        for (int k = 0; k < dict_fill && !hit; k++) begin
            if (close_enough(dict_pairs[k][31:16], hi) &&
                    close_enough(dict_pairs[k][15:0], lo)) begin
                nib = 4'(k);
                hit = 1'b1;
            end
        end
        if (!hit) begin
            if (dict_fill < NUM_PAIRS) begin
                dict_pairs[dict_fill] = {hi, lo};
                nib = 4'(dict_fill);
                dict_fill++;
            end else begin
                flag_ovf = 1'b1;
            end
        end
        pair_nibbles[slot % SLOTS] = nib;
    endfunction

    // Build the frame words that the current code produces.
    function automatic void build_frame();
        logic [7:0]  fbuf [FRAME_LEN];
        logic [7:0]  crc;
        logic [31:0] v;
        int          pairs, data_len, length, nres, nb;
        t_word       w;
        pairs = (dur_count + 1) / 2;
        data_len = (pairs + 1) / 2;
        length = irpf_pkg::HDR_BYTES + DICT_LEN + data_len;
        crc = 8'd0;
        for (int k = 0; k < FRAME_LEN; k++) fbuf[k] = 8'd0;
        for (int k = 0; k < DICT_LEN; k++) begin
            v = (k / 4 < dict_fill) ? dict_pairs[k / 4] : 32'd0;
            fbuf[irpf_pkg::HDR_BYTES + k] = v[8 * (3 - k % 4) +: 8];
        end
        for (int k = 0; k < data_len; k++) begin
            fbuf[irpf_pkg::HDR_BYTES + DICT_LEN + k] = {pair_nibbles[2 * k],
                (2 * k + 1 < pairs) ? pair_nibbles[2 * k + 1] : 4'd0};
        end
        for (int k = irpf_pkg::HDR_BYTES; k < length; k++) crc = crc_step(crc, fbuf[k]);
        fbuf[0] = irpf_pkg::HDR_OPCODE;
        fbuf[1] = 8'(length >> 8);
        fbuf[2] = 8'(length);
        fbuf[3] = carrier;
        fbuf[4] = 8'(pairs >> 8);
        fbuf[5] = 8'(pairs);
        fbuf[8] = irpf_pkg::HDR_VERSION;
        fbuf[9] = crc;
        nres = (length + 7) / 8;
        for (int r = 0; r < nres; r++) begin
            nb = (length - 8 * r > 8) ? 8 : length - 8 * r;
            w.frame_word = '0;
            for (int k = 0; k < 8; k++) begin
                w.frame_word = {w.frame_word[55:0], (k < nb) ? fbuf[8 * r + k] : 8'd0};
            end
            w.bytes_valid = 4'(nb);
            w.status = irpf_pkg::ST_OK;
            w.end_of_frame = (r == nres - 1);
            words_due.push_back(w);
        end
    endfunction

    // Advance the tracked state by one accepted duration.
    function automatic void accept_duration(logic [15:0] dur, logic fin);
        t_word w;
        if (dur_count < NUM_DUR) begin
            dur_count++;
            if (dur_count % 2 == 1) open_high = dur;
            else file_pair(open_high, dur, (dur_count - 1) / 2);
        end else begin
            dur_count = NUM_DUR + 1;
            flag_many = 1'b1;
        end
        if (!fin) return;
        if (!flag_many && dur_count % 2 == 1) file_pair(open_high, 16'd0, (dur_count - 1) / 2);
        w = '0;
        w.end_of_frame = 1'b1;
        if (flag_many) w.status = irpf_pkg::ST_MANY;
        else if (dur_count < irpf_pkg::MIN_DURATIONS) w.status = irpf_pkg::ST_FEW;
        else if (flag_ovf) w.status = irpf_pkg::ST_OVF;
        if (w.status != irpf_pkg::ST_OK) begin
            words_due.push_back(w);
            n_errors++;
        end else begin
            build_frame();
            n_frames++;
        end
        for (int k = 0; k < NUM_PAIRS; k++) dict_pairs[k] = '0;
        dict_fill = 0;
        dur_count = 0;
        open_high = '0;
        flag_many = 1'b0;
        flag_ovf = 1'b0;
    endfunction

    // Sender: bursts of items with random gaps.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.duration <= '0;
            in_ch.last <= 1'b0;
        end else if (!slot_full) begin
            if (gap_left > 0) begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end else if (durations_todo.size() > 0) begin
                irpf_pkg::t_item it;
                it = durations_todo.pop_front();
                in_ch.duration <= it.duration;
                in_ch.last <= it.last;
                in_ch.valid <= 1'b1;
                slot_full = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 8);
                    gap_left = $urandom_range(0, 6);
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern.
    always @(negedge i_clk) begin
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else out_ch.ready <= ($urandom_range(0, 99) < ready_pct);
    end

    // Accepted items and results.
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", n_cycles);
            $display("ir_pulse_dictionary_framer_core_tb: FAIL");
            $finish;
        end
        if (i_rst_n && in_ch.valid && in_ch.ready && slot_full) begin
            accept_duration(in_ch.duration, in_ch.last);
            slot_full = 1'b0;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            t_word got, want;
            got = {out_ch.frame_word, out_ch.bytes_valid, out_ch.status, out_ch.end_of_frame};
            n_words++;
            if (words_due.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result %h", got);
            end else begin
                want = words_due.pop_front();
                if (got.frame_word !== want.frame_word || got.bytes_valid !== want.bytes_valid
                        || got.status !== want.status
                        || got.end_of_frame !== want.end_of_frame) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) begin
                        $display("result %0d: expected word %h bytes %0d status %0d eof %0d",
                                 n_words, want.frame_word, want.bytes_valid, want.status,
                                 want.end_of_frame);
                        $display("result %0d:   actual word %h bytes %0d status %0d eof %0d",
                                 n_words, got.frame_word, got.bytes_valid, got.status,
                                 got.end_of_frame);
                    end
                end
            end
        end
    end

    task automatic queue_duration(logic [15:0] d, logic fin);
        irpf_pkg::t_item it;
        it.duration = d;
        it.last = fin;
        durations_todo.push_back(it);
        n_queued++;
    endtask

    // A code built from a few base pairs, each time jittered by up to one.
    task automatic queue_code(int n, int kinds, int jitter);
        logic [15:0] base [32];
        int          j, d;
        for (int k = 0; k < 32; k++) base[k] = 16'($urandom);
        j = 0;
        for (int i = 0; i < n; i++) begin
            if (i % 2 == 0) j = $urandom_range(0, kinds - 1);
            d = int'(base[2 * j + i % 2]) + $urandom_range(0, 2 * jitter) - jitter;
            if (d < 0) d = 0;
            if (d > 65535) d = 65535;
            queue_duration(16'(d), i == n - 1);
        end
    endtask

    // Wait until the block has drained, then let it settle.
    task automatic drain();
        while (durations_todo.size() > 0 || slot_full || words_due.size() > 0)
            @(posedge i_clk);
        repeat (1500) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_CARRIER) carrier = data[7:0];
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Stimulus.
    initial begin
        int n;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.duration = '0;
        in_ch.last = 1'b0;
        out_ch.ready = 1'b0;
        slot_full = 1'b0;
        burst_left = 0;
        gap_left = 0;
        ready_pct = 100;
        carrier = '0;
        dict_fill = 0;
        dur_count = 0;
        open_high = '0;
        flag_many = 1'b0;
        flag_ovf = 1'b0;
        for (int k = 0; k < NUM_PAIRS; k++) dict_pairs[k] = '0;
        n_cycles = 0;
        n_mismatch = 0;
        n_words = 0;
        n_frames = 0;
        n_errors = 0;
        n_queued = 0;
        wait (i_rst_n);
        repeat (1500) @(posedge i_clk);

        // Directed: short codes, odd counts and extreme times with carrier 0.
        queue_duration(16'd500, 1'b1);
        queue_duration(16'd1, 1'b0);
        queue_duration(16'd2, 1'b0);
        queue_duration(16'd3, 1'b0);
        queue_duration(16'd4, 1'b1);
        queue_duration(16'hFFFF, 1'b0);
        queue_duration(16'h0000, 1'b0);
        queue_duration(16'hFFFE, 1'b0);
        queue_duration(16'h0001, 1'b0);
        queue_duration(16'hFFFF, 1'b1);
        // Neighbors differ by one (match) and by two (new entry).
        queue_duration(16'd1000, 1'b0);
        queue_duration(16'd2000, 1'b0);
        queue_duration(16'd1001, 1'b0);
        queue_duration(16'd1999, 1'b0);
        queue_duration(16'd1002, 1'b0);
        queue_duration(16'd2000, 1'b1);
        drain();

        // Dictionary overflow under a slower receiver.
        apb_write(ADDR_CARRIER, 32'hFF);
        ready_pct = 60;
        for (int k = 0; k < 34; k++) queue_duration(16'(100 * k + 7), k == 33);
        drain();

        // Random codes across several carrier settings and stall rates.
        for (int phase = 0; phase < 4; phase++) begin
            apb_write(ADDR_CARRIER, phase == 0 ? 32'h5A : phase == 2 ? 32'h0 : $urandom);
            ready_pct = (phase == 1) ? 100 : $urandom_range(25, 90);
            for (int f = 0; f < 3; f++) begin
                case ($urandom_range(0, 9))
                    0: begin
                        n = $urandom_range(1, 4);
                        for (int i = 0; i < n; i++) queue_duration(16'($urandom), i == n - 1);
                    end
                    1: begin
                        n = $urandom_range(5, 40);
                        for (int i = 0; i < n; i++) queue_duration(16'($urandom), i == n - 1);
                    end
                    default: queue_code($urandom_range(5, 30), $urandom_range(1, 10),
                                        $urandom_range(0, 1));
                endcase
            end
            // One longer code per phase.
            queue_code($urandom_range(35, 55), $urandom_range(2, 16), 1);
            drain();
        end

        $display("Ran %0d durations: %0d frames and %0d error results, %0d words checked.",
                 n_queued, n_frames, n_errors, n_words);
        $display("Covered short, odd, overflowing and jittered codes over four carrier codes.");
        if (n_mismatch == 0 && words_due.size() == 0) begin
            $display("ir_pulse_dictionary_framer_core_tb: PASS");
        end else begin
            $display("%0d mismatches, %0d results missing", n_mismatch, words_due.size());
            $display("ir_pulse_dictionary_framer_core_tb: FAIL");
        end
        $finish;
    end

endmodule
